### design/rht_pkg.sv
// Package: shared types and constants for the reference-counted handle table.
package rht_pkg;

  localparam int unsigned PoolSlots   = 256;
  localparam int unsigned HandleSlots = 64;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned PoolAw      = (PoolSlots > 1) ? $clog2(PoolSlots) : 1;
  localparam int unsigned HandleAw    = (HandleSlots > 1) ? $clog2(HandleSlots) : 1;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam int unsigned SlotW   = 1 + CountBits;
  localparam int unsigned EntryW  = 1 + 8 + 32;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_REF     = 3'd1,
    OP_DEREF   = 3'd2,
    OP_HALLOC  = 3'd3,
    OP_HGET    = 3'd4,
    OP_HCLOSE  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_POOL_FULL  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_DENIED     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_OBJ,
    S_WRITE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  object_index;
    logic [7:0]  handle_index;
    logic [31:0] access_mask;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  object_out;
    logic [7:0]  handle_out;
    logic [15:0] count_after;
    logic        slot_freed;
  } rsp_t;

  typedef struct packed {
    logic              found;
    logic [PoolAw-1:0] index;
  } pool_free_t;

  typedef struct packed {
    logic                found;
    logic [HandleAw-1:0] index;
  } hnd_free_t;

endpackage

### design/refcounted_object_handle_table.sv
// Top level: reference-counted object pool and handle table.
//
// channel | dir | payload       | handshake
// req     | in  | rht_pkg::req_t | req_valid_i / req_ready_o
// rsp     | out | rht_pkg::rsp_t | rsp_valid_o / rsp_ready_i
//
// A word passes four phases (read handle entry, read count, write back, load result);
// the result is valid once the load-result phase has passed, and the next word is taken
// the cycle after the result leaves, so words are not overlapped.
// Used bits and count valid bits are flip-flops cleared at reset; a count whose valid
// bit is clear reads as zero and an entry is read only behind its used bit.
// A stalled result holds in the output register; the next word waits for it.
module refcounted_object_handle_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rht_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output rht_pkg::rsp_t  rsp_o
);

  localparam int unsigned PAw = rht_pkg::PoolAw;
  localparam int unsigned HAw = rht_pkg::HandleAw;
  localparam int unsigned CB  = rht_pkg::CountBits;

  rht_pkg::state_e state_q, state_d;
  rht_pkg::req_t   req_q;
  rht_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  // count validity: a slot ever written since reset
  logic [rht_pkg::PoolSlots-1:0] cnt_vld_q, cnt_vld_d;

  logic            cnt_we;
  logic [PAw-1:0]  cnt_addr, cnt_waddr;
  logic [CB-1:0]   cnt_wdata, cnt_rdata, cnt_cur;
  logic            ent_we;
  logic [HAw-1:0]  ent_addr;
  logic [rht_pkg::EntryW-1:0] ent_wdata, ent_rdata;
  logic [rht_pkg::EntryW-1:0] ent_q;

  logic            pool_set, pool_clr, pool_used, pool_found;
  logic [PAw-1:0]  pool_addr, pool_free;
  logic            hnd_set, hnd_clr, hnd_used, hnd_found;
  logic [HAw-1:0]  hnd_addr, hnd_free;

  logic            obj_ok, hnd_ok;
  logic [PAw-1:0]  obj_sel;
  logic [PAw-1:0]  tgt_q, tgt_d;
  logic            ent_vld_q, ent_vld_d;

  rht_ram #(.Width(CB), .Depth(rht_pkg::PoolSlots)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_addr), .rdata_o(cnt_rdata)
  );

  rht_ram #(.Width(rht_pkg::EntryW), .Depth(rht_pkg::HandleSlots)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_addr), .wdata_i(ent_wdata),
    .raddr_i(ent_addr), .rdata_o(ent_rdata)
  );

  rht_free_map #(.Depth(rht_pkg::PoolSlots)) u_pool_map (
    .clk_i, .rst_ni, .set_i(pool_set), .clr_i(pool_clr), .addr_i(pool_addr),
    .used_o(pool_used), .found_o(pool_found), .free_o(pool_free)
  );

  rht_free_map #(.Depth(rht_pkg::HandleSlots)) u_hnd_map (
    .clk_i, .rst_ni, .set_i(hnd_set), .clr_i(hnd_clr), .addr_i(hnd_addr),
    .used_o(hnd_used), .found_o(hnd_found), .free_o(hnd_free)
  );

  assign req_ready_o = (state_q == rht_pkg::S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign obj_ok = {1'b0, req_q.object_index} < 9'(rht_pkg::PoolSlots);
  assign hnd_ok = {1'b0, req_q.handle_index} < 9'(rht_pkg::HandleSlots);
  assign obj_sel = PAw'(req_q.object_index);

  // handle entry address: allocate uses the free entry, others the request
  assign hnd_addr = (req_q.op == rht_pkg::OP_HALLOC) ? hnd_free : HAw'(req_q.handle_index);
  assign ent_addr = hnd_addr;
  assign cnt_cur  = cnt_vld_q[tgt_q] ? cnt_rdata : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rht_pkg::S_IDLE:  if (req_valid_i && req_ready_o) state_d = rht_pkg::S_READ;
      rht_pkg::S_READ:  state_d = rht_pkg::S_OBJ;
      rht_pkg::S_OBJ:   state_d = rht_pkg::S_WRITE;
      rht_pkg::S_WRITE: state_d = rht_pkg::S_OUT;
      rht_pkg::S_OUT:   state_d = rht_pkg::S_IDLE;
      default:          state_d = rht_pkg::S_IDLE;
    endcase
  end

  // target object: request's in S_READ; handle entry's or free slot in S_OBJ
  always_comb begin
    tgt_d     = tgt_q;
    ent_vld_d = ent_vld_q;
    if (state_q == rht_pkg::S_READ) begin
      ent_vld_d = hnd_used;
      tgt_d     = obj_sel;
    end
    if (state_q == rht_pkg::S_OBJ) begin
      if (req_q.op == rht_pkg::OP_HGET || req_q.op == rht_pkg::OP_HCLOSE) begin
        tgt_d = (ent_rdata[39:32] < 8'(rht_pkg::PoolSlots - 1) ||
                 ent_rdata[39:32] == 8'(rht_pkg::PoolSlots - 1))
                ? PAw'(ent_rdata[39:32]) : '0;
      end else if (req_q.op == rht_pkg::OP_CREATE) begin
        tgt_d = pool_free;
      end
    end
  end

  assign cnt_addr = tgt_d;

  always_comb begin
    logic [CB-1:0] nc;
    logic          upd, fr;
    nc = cnt_cur; upd = 1'b0; fr = 1'b0;
    cnt_we = 1'b0; cnt_waddr = tgt_q; cnt_wdata = '0;
    ent_we = 1'b0; ent_wdata = '0;
    pool_set = 1'b0; pool_clr = 1'b0; pool_addr = tgt_q;
    hnd_set = 1'b0; hnd_clr = 1'b0;
    cnt_vld_d = cnt_vld_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (state_q == rht_pkg::S_WRITE) begin
      rsp_d = '0;
      case (req_q.op)
        rht_pkg::OP_CREATE: begin
          if (pool_found) begin
            nc = CB'(1); upd = 1'b1; pool_set = 1'b1;
            rsp_d.object_out = 8'(tgt_q);
            rsp_d.count_after = 16'(nc);
          end else rsp_d.status = rht_pkg::ST_POOL_FULL;
        end
        rht_pkg::OP_REF, rht_pkg::OP_DEREF: begin
          if (!obj_ok) rsp_d.status = rht_pkg::ST_BAD_HANDLE;
          else begin
            upd = 1'b1;
            if (req_q.op == rht_pkg::OP_REF) begin
              if (cnt_cur != rht_pkg::CountMax) nc = cnt_cur + CB'(1);
            end else begin
              if (cnt_cur != '0) nc = cnt_cur - CB'(1);
              if (nc == '0) begin fr = pool_used; pool_clr = 1'b1; end
            end
            rsp_d.count_after = 16'(nc);
            rsp_d.slot_freed = fr;
          end
        end
        rht_pkg::OP_HALLOC: begin
          if (!obj_ok) rsp_d.status = rht_pkg::ST_BAD_HANDLE;
          else if (!hnd_found) rsp_d.status = rht_pkg::ST_TABLE_FULL;
          else begin
            upd = 1'b1; hnd_set = 1'b1; ent_we = 1'b1;
            ent_wdata = {1'b1, req_q.object_index, req_q.access_mask};
            if (cnt_cur != rht_pkg::CountMax) nc = cnt_cur + CB'(1);
            rsp_d.handle_out = 8'(hnd_free);
            rsp_d.count_after = 16'(nc);
          end
        end
        rht_pkg::OP_HGET, rht_pkg::OP_HCLOSE: begin
          if (!hnd_ok) rsp_d.status = rht_pkg::ST_BAD_HANDLE;
          else if (!ent_vld_q) rsp_d.status = rht_pkg::ST_EMPTY;
          else if (req_q.op == rht_pkg::OP_HGET) begin
            if ((ent_q[31:0] & req_q.access_mask) != req_q.access_mask)
              rsp_d.status = rht_pkg::ST_DENIED;
            else begin
              rsp_d.object_out = 8'(tgt_q);
              rsp_d.count_after = 16'(cnt_cur);
            end
          end else begin
            upd = 1'b1; hnd_clr = 1'b1;
            if (cnt_cur != '0) nc = cnt_cur - CB'(1);
            if (nc == '0) begin fr = pool_used; pool_clr = 1'b1; end
            rsp_d.count_after = 16'(nc);
            rsp_d.slot_freed = fr;
          end
        end
        default: rsp_d = '0;
      endcase
      if (upd) begin
        cnt_we = 1'b1; cnt_wdata = nc; cnt_vld_d[tgt_q] = 1'b1;
      end
    end
    if (state_q == rht_pkg::S_OUT) rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    if (state_q == rht_pkg::S_OBJ) ent_q <= ent_rdata;
    rsp_q <= rsp_d;
    tgt_q <= tgt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rht_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
      ent_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_vld_q   <= cnt_vld_d;
      ent_vld_q   <= ent_vld_d;
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("accepted while result pending");
  a_rsp_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rht_pkg::S_WRITE) |=> ##1 rsp_valid_o) else $error("result missing");
  a_no_double_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pool_set && pool_clr)) else $error("pool set and clear together");
`endif

endmodule

### design/rht_ram.sv
// Generic RAM with one write port and one registered read port.
module rht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/rht_free_map.sv
// Occupancy bit map with lowest-free-entry search.
module rht_free_map #(
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          set_i,
  input  logic          clr_i,
  input  logic [Aw-1:0] addr_i,
  output logic          used_o,
  output logic          found_o,
  output logic [Aw-1:0] free_o
);

  logic [Depth-1:0] used_q, used_d;
  logic          found_q;
  logic [Aw-1:0] free_q;
  logic          found_c;
  logic [Aw-1:0] free_c;

  always_comb begin
    used_d = used_q;
    if (set_i) used_d[addr_i] = 1'b1;
    if (clr_i) used_d[addr_i] = 1'b0;
  end

  always_comb begin
    found_c = 1'b0;
    free_c  = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        found_c = 1'b1;
        free_c  = Aw'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      found_q <= 1'b0;
      free_q  <= '0;
    end else begin
      used_q  <= used_d;
      found_q <= found_c;
      free_q  <= free_c;
    end
  end

  assign used_o  = used_q[addr_i];
  assign found_o = found_q;
  assign free_o  = free_q;

endmodule

### tb/tb_top.sv
// Testbench for the reference-counted object pool and handle table.
module tb_top;

  localparam int unsigned CycleLimit = 400000;

  logic           clk_i;
  logic           rst_ni;
  logic           req_valid_i;
  logic           req_ready_o;
  rht_pkg::req_t  req_i;
  logic           rsp_valid_o;
  logic           rsp_ready_i;
  rht_pkg::rsp_t  rsp_o;

  refcounted_object_handle_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  logic                          pool_used [rht_pkg::PoolSlots];
  logic [rht_pkg::CountBits-1:0] pool_count [rht_pkg::PoolSlots];
  logic                          hnd_valid [rht_pkg::HandleSlots];
  logic [7:0]                    hnd_obj [rht_pkg::HandleSlots];
  logic [31:0]                   hnd_acc [rht_pkg::HandleSlots];

  rht_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  int   words_sent;
  int   rsps_seen = 0;
  int   cycles = 0;
  bit   hold_off;
  bit   sink_no_idle;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout, %0d results pending", $time, expected_rsps.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic count_drop(input int unsigned slot);
    if (pool_count[slot] != '0) pool_count[slot] = pool_count[slot] - 1'b1;
    if (pool_count[slot] == '0) begin
      count_drop = pool_used[slot];
      pool_used[slot] = 1'b0;
    end else begin
      count_drop = 1'b0;
    end
  endfunction

  function automatic void count_raise(input int unsigned slot);
    if (pool_count[slot] != rht_pkg::CountMax) pool_count[slot] = pool_count[slot] + 1'b1;
  endfunction

  function automatic rht_pkg::rsp_t apply_op(input rht_pkg::req_t w);
    rht_pkg::rsp_t r;
    int unsigned o;
    r = '0;
    case (w.op)
      rht_pkg::OP_CREATE: begin
        r.status = rht_pkg::ST_POOL_FULL;
        for (int i = 0; i < rht_pkg::PoolSlots; i++) begin
          if (!pool_used[i]) begin
            pool_used[i] = 1'b1;
            pool_count[i] = rht_pkg::CountBits'(1);
            r.status = rht_pkg::ST_OK;
            r.object_out = 8'(i);
            r.count_after = 16'd1;
            break;
          end
        end
      end
      rht_pkg::OP_REF, rht_pkg::OP_DEREF: begin
        if (w.object_index >= rht_pkg::PoolSlots) begin
          r.status = rht_pkg::ST_BAD_HANDLE;
        end else begin
          if (w.op == rht_pkg::OP_REF) count_raise(32'(w.object_index));
          else r.slot_freed = count_drop(32'(w.object_index));
          r.count_after = pool_count[w.object_index];
        end
      end
      rht_pkg::OP_HALLOC: begin
        if (w.object_index >= rht_pkg::PoolSlots) begin
          r.status = rht_pkg::ST_BAD_HANDLE;
        end else begin
          r.status = rht_pkg::ST_TABLE_FULL;
          for (int i = 0; i < rht_pkg::HandleSlots; i++) begin
            if (!hnd_valid[i]) begin
              hnd_valid[i] = 1'b1;
              hnd_obj[i] = w.object_index;
              hnd_acc[i] = w.access_mask;
              count_raise(32'(w.object_index));
              r.status = rht_pkg::ST_OK;
              r.handle_out = 8'(i);
              r.count_after = pool_count[w.object_index];
              break;
            end
          end
        end
      end
      rht_pkg::OP_HGET, rht_pkg::OP_HCLOSE: begin
        if (w.handle_index >= rht_pkg::HandleSlots) begin
          r.status = rht_pkg::ST_BAD_HANDLE;
        end else if (!hnd_valid[w.handle_index]) begin
          r.status = rht_pkg::ST_EMPTY;
        end else begin
          o = 32'(hnd_obj[w.handle_index]);
          if (o >= rht_pkg::PoolSlots) o = 0;
          if (w.op == rht_pkg::OP_HGET) begin
            if ((hnd_acc[w.handle_index] & w.access_mask) != w.access_mask) begin
              r.status = rht_pkg::ST_DENIED;
            end else begin
              r.object_out = 8'(o);
              r.count_after = pool_count[o];
            end
          end else begin
            r.slot_freed = count_drop(o);
            r.count_after = pool_count[o];
            hnd_valid[w.handle_index] = 1'b0;
            hnd_obj[w.handle_index] = '0;
            hnd_acc[w.handle_index] = '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input rht_pkg::req_t w, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    req_valid_i = 1'b1;
    req_i = w;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    expected_rsps.push_back(apply_op(w));
    words_sent++;
    @(negedge clk_i);
    req_valid_i = 1'b0;
  endtask

  function automatic rht_pkg::req_t make_word(input logic [2:0] op, input logic [7:0] obj,
                                              input logic [7:0] hnd, input logic [31:0] acc);
    rht_pkg::req_t w;
    w.op = op;
    w.object_index = obj;
    w.handle_index = hnd;
    w.access_mask = acc;
    return w;
  endfunction

  task automatic drain();
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      rsps_seen++;
      if (expected_rsps.size() == 0) begin
        $display("%0t unexpected result %h", $time, rsp_o);
        errors++;
      end else begin
        rht_pkg::rsp_t e;
        e = expected_rsps.pop_front();
        if (e.status !== rsp_o.status)
          $display("%0t status exp %0d got %0d", $time, e.status, rsp_o.status);
        if (e.object_out !== rsp_o.object_out)
          $display("%0t object_out exp %0d got %0d", $time, e.object_out, rsp_o.object_out);
        if (e.handle_out !== rsp_o.handle_out)
          $display("%0t handle_out exp %0d got %0d", $time, e.handle_out, rsp_o.handle_out);
        if (e.count_after !== rsp_o.count_after)
          $display("%0t count_after exp %0d got %0d", $time, e.count_after,
                   rsp_o.count_after);
        if (e.slot_freed !== rsp_o.slot_freed)
          $display("%0t slot_freed exp %0d got %0d", $time, e.slot_freed, rsp_o.slot_freed);
        if (e !== rsp_o) errors++;
      end
    end
  end

  // result sink: while not held off, wait a random stall per word (none when sink_no_idle), then take it
  initial begin
    int stall;
    rsp_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off || !rsp_valid_o) begin
        rsp_ready_i <= 1'b0;
      end else begin
        stall = sink_no_idle ? 0 : $urandom_range(0, 13);
        repeat (stall) @(negedge clk_i);
        rsp_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic test_directed();
    send_word(make_word(rht_pkg::OP_DEREF, 8'd0, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_CREATE, 8'd0, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_CREATE, 8'd255, 8'd255, 32'hFFFF_FFFF));
    send_word(make_word(rht_pkg::OP_REF, 8'd255, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_REF, 8'd7, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_DEREF, 8'd7, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_HALLOC, 8'd0, 8'd0, 32'hA5A5_5A5A));
    send_word(make_word(rht_pkg::OP_HALLOC, 8'd255, 8'd0, 32'hFFFF_FFFF));
    send_word(make_word(rht_pkg::OP_HGET, 8'd0, 8'd0, 32'hA5A5_5A5A));
    send_word(make_word(rht_pkg::OP_HGET, 8'd0, 8'd0, 32'hFFFF_FFFF));
    send_word(make_word(rht_pkg::OP_HGET, 8'd0, 8'd1, 32'd0));
    send_word(make_word(rht_pkg::OP_HGET, 8'd0, 8'd255, 32'd0));
    send_word(make_word(rht_pkg::OP_HGET, 8'd0, 8'd64, 32'd0));
    send_word(make_word(rht_pkg::OP_HCLOSE, 8'd0, 8'd200, 32'd0));
    send_word(make_word(rht_pkg::OP_HCLOSE, 8'd0, 8'd5, 32'd0));
    send_word(make_word(rht_pkg::OP_HCLOSE, 8'd0, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_DEREF, 8'd0, 8'd0, 32'd0));
    send_word(make_word(rht_pkg::OP_DEREF, 8'd1, 8'd0, 32'd0));
    send_word(make_word(3'd6, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_word(make_word(3'd7, 8'h00, 8'h00, 32'h0));
    drain();
  endtask

  task automatic test_fill_tables();
    for (int i = 0; i < rht_pkg::PoolSlots + 2; i++)
      send_word(make_word(rht_pkg::OP_CREATE, 8'($urandom), 8'($urandom), $urandom), 1'b1);
    for (int i = 0; i < rht_pkg::HandleSlots + 2; i++)
      send_word(make_word(rht_pkg::OP_HALLOC, 8'($urandom_range(0, 3)), 8'($urandom),
                          $urandom), 1'b1);
    for (int i = 0; i < rht_pkg::HandleSlots; i++)
      send_word(make_word(rht_pkg::OP_HCLOSE, 8'd0, 8'(i), 32'd0), 1'b1);
    for (int i = 0; i < 32; i++)
      send_word(make_word(rht_pkg::OP_DEREF, 8'(i), 8'd0, 32'd0), 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++)
        send_word(make_word(rht_pkg::OP_REF, 8'($urandom_range(0, 3)), 8'd0, 32'd0), 1'b1);
    join
    drain();
  endtask

  task automatic test_random();
    rht_pkg::req_t w;
    int pick;
    for (int i = 0; i < 330; i++) begin
      sink_no_idle = (i % 100) < 20;
      pick = $urandom_range(0, 99);
      w.op = (pick < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      w.object_index = (pick < 85) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      w.handle_index = (pick < 80) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      w.access_mask = (pick % 3 == 0) ? $urandom : $urandom_range(0, 15);
      send_word(w, sink_no_idle);
      if (i == 165) drain();
    end
    sink_no_idle = 1'b0;
    drain();
  endtask

  initial begin
    words_sent = 0;
    hold_off = 1'b0;
    sink_no_idle = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    for (int i = 0; i < rht_pkg::PoolSlots; i++) begin
      pool_used[i] = 1'b0;
      pool_count[i] = '0;
    end
    for (int i = 0; i < rht_pkg::HandleSlots; i++) begin
      hnd_valid[i] = 1'b0;
      hnd_obj[i] = '0;
      hnd_acc[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill_tables();
    test_backpressure();
    test_random();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d words and %0d results: all ops, full pool and table,", words_sent,
             rsps_seen);
    $display("bad and empty handles, access denial, long output stall.");
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
